FILE: src/rigid_body_euler_integrator_defines.svh
// Assertion macros shared by the integrator RTL.
`ifndef RIGID_BODY_EULER_INTEGRATOR_DEFINES_SVH
`define RIGID_BODY_EULER_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RBEI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RBEI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rbei_pkg.sv
package rbei_pkg;

    localparam logic [1:0] MODE_EXPLICIT = 2'd0;
    localparam logic [1:0] MODE_SEMI     = 2'd1;
    localparam logic [1:0] MODE_KINEMATIC = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_DT   = 1'b1;

    localparam logic [1:0]  MODE_RESET = MODE_EXPLICIT;
    localparam logic [15:0] DT_RESET   = 16'd1092;

    localparam logic signed [31:0] Q30_ONE  = 32'sh4000_0000;
    localparam logic signed [31:0] S32_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] QUAT_MIN = 32'sh8000_0001;

    typedef struct packed {
        logic       done;
        logic [31:0] root;
    } t_sqrt_res;

    typedef struct packed {
        logic       done;
        logic       ovf;
        logic [31:0] quo;
    } t_div_res;

    // One term of the quaternion derivative: rate index, quaternion index,
    // destination sum and sign.
    typedef struct packed {
        logic [1:0] ri;
        logic [1:0] qi;
        logic [1:0] dst;
        logic       neg;
    } t_qd_term;

    function automatic t_qd_term qd_term(input logic [3:0] k);
        t_qd_term t;
        case (k)
            4'd0:    t = '{ri: 2'd1, qi: 2'd2, dst: 2'd0, neg: 1'b0};
            4'd1:    t = '{ri: 2'd2, qi: 2'd1, dst: 2'd0, neg: 1'b1};
            4'd2:    t = '{ri: 2'd0, qi: 2'd3, dst: 2'd0, neg: 1'b0};
            4'd3:    t = '{ri: 2'd2, qi: 2'd0, dst: 2'd1, neg: 1'b0};
            4'd4:    t = '{ri: 2'd0, qi: 2'd2, dst: 2'd1, neg: 1'b1};
            4'd5:    t = '{ri: 2'd1, qi: 2'd3, dst: 2'd1, neg: 1'b0};
            4'd6:    t = '{ri: 2'd0, qi: 2'd1, dst: 2'd2, neg: 1'b0};
            4'd7:    t = '{ri: 2'd1, qi: 2'd0, dst: 2'd2, neg: 1'b1};
            4'd8:    t = '{ri: 2'd2, qi: 2'd3, dst: 2'd2, neg: 1'b0};
            4'd9:    t = '{ri: 2'd0, qi: 2'd0, dst: 2'd3, neg: 1'b1};
            4'd10:   t = '{ri: 2'd1, qi: 2'd1, dst: 2'd3, neg: 1'b1};
            4'd11:   t = '{ri: 2'd2, qi: 2'd2, dst: 2'd3, neg: 1'b1};
            default: t = '{ri: 2'd0, qi: 2'd0, dst: 2'd0, neg: 1'b0};
        endcase
        return t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = S32_MAX;
        end else if (v < -36'sd2147483648) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // floor((p + 2^15) / 2^16) for products that stay well inside 48 bits.
    function automatic logic signed [33:0] rnd16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd32768;
        return t[49:16];
    endfunction

endpackage

FILE: src/rbei_in_if.sv
interface rbei_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic signed [31:0] ang_acc_x;
    logic signed [31:0] ang_acc_y;
    logic signed [31:0] ang_acc_z;

    modport source(output valid, op, acc_x, acc_y, acc_z, ang_acc_x, ang_acc_y,
                   ang_acc_z, input ready);
    modport sink(input valid, op, acc_x, acc_y, acc_z, ang_acc_x, ang_acc_y,
                 ang_acc_z, output ready);
endinterface

FILE: src/rbei_out_if.sv
interface rbei_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] rot_w;
    logic               moving;
    logic               rotating;

    modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, rot_x,
                   rot_y, rot_z, rot_w, moving, rotating, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, rot_x,
                 rot_y, rot_z, rot_w, moving, rotating, output ready);
endinterface

FILE: src/rbei_mul.sv
module rbei_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_prod
);
    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

FILE: src/rbei_isqrt.sv
module rbei_isqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [63:0]           i_n,
    output rbei_pkg::t_sqrt_res   o_res
);
    logic [63:0] r_n;
    logic [32:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [34:0] w_rs;
    logic [34:0] w_trial;
    logic        w_take;
    logic [34:0] w_diff;

    // Two radicand bits enter per step; the root gains one bit.
    assign w_rs    = {r_rem, r_n[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_take  = (w_rs >= w_trial);
    assign w_diff  = w_rs - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n <= {r_n[61:0], 2'b00};
            if (w_take) begin
                r_rem  <= w_diff[32:0];
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= w_rs[32:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.root = r_root;
endmodule

FILE: src/rbei_div.sv
module rbei_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [30:0]         i_mag,
    input  logic [31:0]         i_den,
    output rbei_pkg::t_div_res  o_res
);
    logic [31:0] r_rem;
    logic [31:0] r_num;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic        r_ovf;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_sh;
    logic        w_take;
    logic [32:0] w_diff;

    // The dividend is mag * 2^30; its top part mag >> 2 seeds the remainder,
    // and a quotient that would need more than 32 bits is flagged up front.
    assign w_sh   = {r_rem, r_num[31]};
    assign w_take = (w_sh >= {1'b0, r_den});
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {3'b000, i_mag[30:2]};
            r_num <= {i_mag[1:0], 30'd0};
            r_quo <= '0;
            r_den <= i_den;
            r_ovf <= ({3'b000, i_mag[30:2]} >= i_den);
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            if (w_take) begin
                r_rem <= w_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quo  = r_quo;
endmodule

FILE: src/rigid_body_euler_integrator.sv
// Fixed-point rigid body integrator for one body. It holds position and velocity
// (Q16.16), angular rate (Q16.16) and the orientation quaternion (Q2.30), and each
// input word either clears that state or advances it by one step dt (Q0.16, written
// through the configuration port together with the mode). Every input word gives
// exactly one output word with the state after the step. All products go through
// one shared 33x33 multiplier under a small sequencer, and the quaternion is
// renormalized by a bit-serial square root and a bit-serial divider, which is run
// once per component. An explicit or semi-implicit step spends most of its time in
// the square root and the four divisions; a clear, an unused mode or a kinematic
// step skips them. The input is ready only while the sequencer is idle; a finished
// word waits in the output register, and the next word can be accepted while it
// waits.
`include "rigid_body_euler_integrator_defines.svh"

module rigid_body_euler_integrator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    rbei_in_if.sink     i_in,
    rbei_out_if.source  o_out
);
    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_POS  = 12'b0000_0000_0010,
        S_VEL  = 12'b0000_0000_0100,
        S_RATE = 12'b0000_0000_1000,
        S_KH   = 12'b0000_0001_0000,
        S_KIN  = 12'b0000_0010_0000,
        S_QD   = 12'b0000_0100_0000,
        S_QS   = 12'b0000_1000_0000,
        S_SQ   = 12'b0001_0000_0000,
        S_SQRT = 12'b0010_0000_0000,
        S_DIV  = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    logic [1:0]  r_mode;
    logic [15:0] r_dt;
    logic [15:0] r_h;
    logic [1:0]  r_i;
    logic [1:0]  r_ph;
    logic [3:0]  r_k;

    logic signed [31:0] r_pos  [3];
    logic signed [31:0] r_vel  [3];
    logic signed [31:0] r_rate [3];
    logic signed [31:0] r_q    [4];
    logic signed [31:0] r_acc  [3];
    logic signed [31:0] r_aacc [3];
    logic signed [49:0] r_d    [4];
    logic signed [40:0] r_t;
    logic [63:0]        r_sum;

    logic               r_ovalid;
    logic signed [31:0] r_opos [3];
    logic signed [31:0] r_ovel [3];
    logic signed [31:0] r_orot [4];
    logic               r_omov;
    logic               r_orot_nz;

    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] w_prod;
    logic signed [32:0] w_dt33;
    logic signed [47:0] w_dc;
    logic [63:0]        w_sum_nxt;
    logic               w_last_axis;
    logic               w_load;

    rbei_pkg::t_qd_term  w_qi;
    rbei_pkg::t_qd_term  w_qc;
    rbei_pkg::t_sqrt_res w_sq;
    rbei_pkg::t_div_res  w_dv;
    logic                w_sq_start;
    logic                w_dv_start;
    logic [1:0]          w_dv_idx;
    logic signed [31:0]  w_dv_q;
    logic [30:0]         w_dv_mag;

    logic signed [49:0] w_term;
    logic signed [63:0] w_full;
    logic signed [63:0] w_full_r;
    logic signed [47:0] w_qn;
    logic signed [31:0] w_qclamp;
    logic signed [31:0] w_qnorm;

    assign w_dt33    = {17'd0, r_dt};
    assign w_qi      = rbei_pkg::qd_term(r_k);
    assign w_qc      = rbei_pkg::qd_term(r_k - 4'd1);
    assign w_sum_nxt = r_sum + w_prod[63:0];
    assign w_last_axis = (r_i == 2'd2);

    // Clamp the accumulated derivative to 48 bits before it is scaled by dt.
    always_comb begin
        if (r_d[r_i] > 50'sh0_7fff_ffff_ffff) begin
            w_dc = 48'sh7fff_ffff_ffff;
        end else if (r_d[r_i] < -50'sh0_8000_0000_0000) begin
            w_dc = 48'sh8000_0000_0000;
        end else begin
            w_dc = r_d[r_i][47:0];
        end
    end

    // Multiplier operands for the current step.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_POS: begin
                w_ma = {r_vel[r_i][31], r_vel[r_i]};
                w_mb = w_dt33;
            end
            S_VEL: begin
                w_ma = {r_acc[r_i][31], r_acc[r_i]};
                w_mb = w_dt33;
            end
            S_RATE: begin
                w_ma = {r_aacc[r_i][31], r_aacc[r_i]};
                w_mb = w_dt33;
            end
            S_KH: begin
                w_ma = w_dt33;
                w_mb = w_dt33;
            end
            S_KIN: begin
                if (r_ph == 2'd0) begin
                    w_ma = {r_vel[r_i][31], r_vel[r_i]};
                    w_mb = w_dt33;
                end else begin
                    w_ma = {r_acc[r_i][31], r_acc[r_i]};
                    w_mb = {17'd0, r_h};
                end
            end
            S_QD: begin
                w_ma = {r_rate[w_qi.ri][31], r_rate[w_qi.ri]};
                w_mb = {r_q[w_qi.qi][31], r_q[w_qi.qi]};
            end
            S_QS: begin
                // Low 24 bits first (unsigned), then the signed upper part.
                if (r_ph == 2'd0) begin
                    w_ma = {9'd0, w_dc[23:0]};
                end else begin
                    w_ma = {{9{w_dc[47]}}, w_dc[47:24]};
                end
                w_mb = w_dt33;
            end
            S_SQ: begin
                w_ma = {r_q[r_k[1:0]][31], r_q[r_k[1:0]]};
                w_mb = {r_q[r_k[1:0]][31], r_q[r_k[1:0]]};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    rbei_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    assign w_sq_start = (r_state == S_SQ) && (r_k == 4'd4);

    rbei_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_n     (w_sum_nxt),
        .o_res   (w_sq)
    );

    assign w_dv_start = ((r_state == S_SQRT) && w_sq.done && (w_sq.root != 32'd0)) ||
                        ((r_state == S_DIV) && w_dv.done && (r_i != 2'd3));
    assign w_dv_idx   = (r_state == S_SQRT) ? 2'd0 : 2'(r_i + 2'd1);
    assign w_dv_q     = r_q[w_dv_idx];
    assign w_dv_mag   = w_dv_q[31] ? 31'(-w_dv_q) : w_dv_q[30:0];

    rbei_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_mag   (w_dv_mag),
        .i_den   (w_sq.root),
        .o_res   (w_dv)
    );

    // Datapath helpers for the quaternion steps.
    assign w_term   = {{2{w_prod[63]}}, w_prod[63:16]};
    assign w_full   = {w_prod[39:0], 24'd0} + {{23{r_t[40]}}, r_t};
    assign w_full_r = w_full + 64'sd65536;
    assign w_qn     = {{16{r_q[r_i][31]}}, r_q[r_i]} + {w_full_r[63], w_full_r[63:17]};

    always_comb begin
        if (w_qn > 48'sd2147483647) begin
            w_qclamp = rbei_pkg::S32_MAX;
        end else if (w_qn < -48'sd2147483647) begin
            w_qclamp = rbei_pkg::QUAT_MIN;
        end else begin
            w_qclamp = w_qn[31:0];
        end
    end

    always_comb begin
        if (r_q[r_i][31]) begin
            w_qnorm = (w_dv.ovf || w_dv.quo[31]) ? rbei_pkg::S32_MIN : -w_dv.quo;
        end else begin
            w_qnorm = (w_dv.ovf || w_dv.quo[31]) ? rbei_pkg::S32_MAX : w_dv.quo;
        end
    end

    assign w_load     = (r_state == S_OUT) && (!r_ovalid || o_out.ready);
    assign i_in.ready = (r_state == S_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rbei_pkg::MODE_RESET;
            r_dt   <= rbei_pkg::DT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbei_pkg::CFG_MODE: r_mode <= i_cfg_data[1:0];
                rbei_pkg::CFG_DT:   r_dt   <= i_cfg_data;
                default:            r_mode <= r_mode;
            endcase
        end
    end

    // Sequencer and body state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_ph    <= '0;
            r_k     <= '0;
            for (int n = 0; n < 3; n++) begin
                r_pos[n]  <= '0;
                r_vel[n]  <= '0;
                r_rate[n] <= '0;
            end
            r_q[0] <= '0;
            r_q[1] <= '0;
            r_q[2] <= '0;
            r_q[3] <= rbei_pkg::Q30_ONE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_acc[0]  <= i_in.acc_x;
                        r_acc[1]  <= i_in.acc_y;
                        r_acc[2]  <= i_in.acc_z;
                        r_aacc[0] <= i_in.ang_acc_x;
                        r_aacc[1] <= i_in.ang_acc_y;
                        r_aacc[2] <= i_in.ang_acc_z;
                        r_i  <= '0;
                        r_ph <= '0;
                        if (i_in.op == rbei_pkg::OP_CLEAR) begin
                            for (int n = 0; n < 3; n++) begin
                                r_pos[n]  <= '0;
                                r_vel[n]  <= '0;
                                r_rate[n] <= '0;
                            end
                            r_q[0] <= '0;
                            r_q[1] <= '0;
                            r_q[2] <= '0;
                            r_q[3] <= rbei_pkg::Q30_ONE;
                            r_state <= S_OUT;
                        end else begin
                            case (r_mode)
                                rbei_pkg::MODE_EXPLICIT:  r_state <= S_POS;
                                rbei_pkg::MODE_SEMI:      r_state <= S_VEL;
                                rbei_pkg::MODE_KINEMATIC: r_state <= S_KH;
                                default:                  r_state <= S_OUT;
                            endcase
                        end
                    end
                end
                S_POS, S_VEL, S_RATE: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        r_i  <= w_last_axis ? 2'd0 : 2'(r_i + 2'd1);
                        case (r_state)
                            S_POS:   r_pos[r_i]  <= rbei_pkg::sat32(36'(r_pos[r_i]) +
                                                    36'(rbei_pkg::rnd16(w_prod)));
                            S_VEL:   r_vel[r_i]  <= rbei_pkg::sat32(36'(r_vel[r_i]) +
                                                    36'(rbei_pkg::rnd16(w_prod)));
                            default: r_rate[r_i] <= rbei_pkg::sat32(36'(r_rate[r_i]) +
                                                    36'(rbei_pkg::rnd16(w_prod)));
                        endcase
                        if (w_last_axis) begin
                            r_k <= '0;
                            for (int n = 0; n < 4; n++) begin
                                r_d[n] <= '0;
                            end
                            case (r_state)
                                S_POS:   r_state <= (r_mode == rbei_pkg::MODE_EXPLICIT) ?
                                                    S_VEL : S_RATE;
                                S_VEL:   r_state <= (r_mode == rbei_pkg::MODE_EXPLICIT) ?
                                                    S_QD : S_POS;
                                default: r_state <= (r_mode == rbei_pkg::MODE_EXPLICIT) ?
                                                    S_OUT : S_QD;
                            endcase
                        end
                    end
                end
                S_KH: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_h     <= 16'(({1'b0, w_prod[31:0]} + 33'd65536) >> 17);
                        r_ph    <= 2'd0;
                        r_state <= S_KIN;
                    end
                end
                S_KIN: begin
                    case (r_ph)
                        2'd0: r_ph <= 2'd1;
                        2'd1: begin
                            r_t  <= 41'(rbei_pkg::rnd16(w_prod));
                            r_ph <= 2'd2;
                        end
                        default: begin
                            r_pos[r_i] <= rbei_pkg::sat32(36'(r_pos[r_i]) + 36'(r_t) +
                                                          36'(rbei_pkg::rnd16(w_prod)));
                            r_ph <= 2'd0;
                            r_i  <= w_last_axis ? 2'd0 : 2'(r_i + 2'd1);
                            if (w_last_axis) begin
                                r_state <= S_OUT;
                            end
                        end
                    endcase
                end
                S_QD: begin
                    if (r_k != 4'd0) begin
                        r_d[w_qc.dst] <= w_qc.neg ? r_d[w_qc.dst] - w_term :
                                                    r_d[w_qc.dst] + w_term;
                    end
                    if (r_k == 4'd12) begin
                        r_k     <= '0;
                        r_i     <= '0;
                        r_ph    <= '0;
                        r_state <= S_QS;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_QS: begin
                    case (r_ph)
                        2'd0: r_ph <= 2'd1;
                        2'd1: begin
                            r_t  <= w_prod[40:0];
                            r_ph <= 2'd2;
                        end
                        default: begin
                            r_q[r_i] <= w_qclamp;
                            r_ph     <= 2'd0;
                            r_i      <= 2'(r_i + 2'd1);
                            if (r_i == 2'd3) begin
                                r_k     <= '0;
                                r_sum   <= '0;
                                r_state <= S_SQ;
                            end
                        end
                    endcase
                end
                S_SQ: begin
                    if (r_k != 4'd0) begin
                        r_sum <= w_sum_nxt;
                    end
                    if (r_k == 4'd4) begin
                        r_state <= S_SQRT;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_SQRT: begin
                    if (w_sq.done) begin
                        r_i <= '0;
                        if (w_sq.root == 32'd0) begin
                            // A zero quaternion falls back to identity.
                            r_q[0] <= '0;
                            r_q[1] <= '0;
                            r_q[2] <= '0;
                            r_q[3] <= rbei_pkg::Q30_ONE;
                            r_ph   <= '0;
                            r_state <= (r_mode == rbei_pkg::MODE_EXPLICIT) ? S_RATE : S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_dv.done) begin
                        r_q[r_i] <= w_qnorm;
                        r_i      <= 2'(r_i + 2'd1);
                        if (r_i == 2'd3) begin
                            r_ph    <= '0;
                            r_state <= (r_mode == rbei_pkg::MODE_EXPLICIT) ? S_RATE : S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int n = 0; n < 3; n++) begin
                r_opos[n] <= r_pos[n];
                r_ovel[n] <= r_vel[n];
            end
            for (int n = 0; n < 4; n++) begin
                r_orot[n] <= r_q[n];
            end
            r_omov    <= (r_vel[0] != '0) || (r_vel[1] != '0) || (r_vel[2] != '0);
            r_orot_nz <= (r_rate[0] != '0) || (r_rate[1] != '0) || (r_rate[2] != '0);
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.pos_x    = r_opos[0];
    assign o_out.pos_y    = r_opos[1];
    assign o_out.pos_z    = r_opos[2];
    assign o_out.vel_x    = r_ovel[0];
    assign o_out.vel_y    = r_ovel[1];
    assign o_out.vel_z    = r_ovel[2];
    assign o_out.rot_x    = r_orot[0];
    assign o_out.rot_y    = r_orot[1];
    assign o_out.rot_z    = r_orot[2];
    assign o_out.rot_w    = r_orot[3];
    assign o_out.moving   = r_omov;
    assign o_out.rotating = r_orot_nz;

    `RBEI_ASSERT_NXT(a_accept_busy, i_in.valid && i_in.ready, r_state != S_IDLE, "accepted word did not start the sequencer")
    `RBEI_ASSERT_IMP(a_out_from_seq, $rose(r_ovalid), $past(r_state) == S_OUT, "output word appeared outside the result step")
    `RBEI_ASSERT_IMP(a_div_nonzero, r_state == S_DIV, w_sq.root != 32'd0, "normalization divides by a zero norm")
    `RBEI_ASSERT_IMP(a_qd_bound, r_state == S_QD, r_k <= 4'd12, "derivative step counter ran past its last term")
endmodule
